// File: src/anxb_pkg.sv
// ----------------------------------------------------------------------------
// anxb_pkg
// Shared types and constants for the Annex B NAL splitter.
// ----------------------------------------------------------------------------
package anxb_pkg;

  // Queue depth between the byte classifier and the result emitter.
  localparam int ANXB_QUEUE_DEPTH = 4;

  // Largest number of results that one input byte can cause.
  localparam int ANXB_MAX_RESULTS = 5;
  localparam int ANXB_CNT_W       = $clog2(ANXB_MAX_RESULTS + 1);

  // Byte values that make up a start code.
  localparam logic [7:0] ANXB_ZERO_BYTE = 8'h00;
  localparam logic [7:0] ANXB_ONE_BYTE  = 8'h01;

  // Held zero count at which the run is saturated.
  localparam logic [1:0] ANXB_ZRUN_MAX = 2'd3;

  typedef enum logic [1:0] {
    CLS_ZERO,
    CLS_START,
    CLS_OTHER
  } anxb_class_t;

  // Work for one input byte: cnt results, the first one is held_byte when
  // head_held is set, the last one is data when tail_data is set, and every
  // other one is a zero byte.
  typedef struct packed {
    logic [ANXB_CNT_W-1:0] cnt;
    logic [7:0]            held;
    logic [7:0]            data;
    logic                  head_held;
    logic                  tail_data;
    logic                  first;
    logic                  last;
  } anxb_desc_t;

endpackage

// File: src/anxb_front.sv
// ----------------------------------------------------------------------------
// anxb_front
// Classifies each stream byte, tracks start code state and builds the
// descriptor of the results that the byte causes.
// ----------------------------------------------------------------------------
module anxb_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                byte_valid,
  output logic                byte_ready,
  input  logic [7:0]          data_byte,
  input  logic                end_of_buffer,
  input  logic                q_full,
  output logic                q_push,
  output anxb_pkg::anxb_desc_t q_desc
);
  import anxb_pkg::*;

  logic [7:0]  held_byte;
  logic        held_valid;
  logic [1:0]  zero_run;
  logic        inside_nal;
  logic        first_pending;

  logic [7:0]  held_byte_next;
  logic        held_valid_next;
  logic [1:0]  zero_run_next;
  logic        inside_nal_next;
  logic        first_pending_next;

  anxb_class_t        cls;
  logic [ANXB_CNT_W-1:0] cnt;
  logic [ANXB_CNT_W-1:0] hv_w;
  logic [ANXB_CNT_W-1:0] zr_w;
  logic [ANXB_CNT_W-1:0] eob_w;
  logic               accept;

  assign byte_ready = !q_full;
  assign accept     = byte_valid && byte_ready;

  assign hv_w  = ANXB_CNT_W'(held_valid);
  assign zr_w  = ANXB_CNT_W'(zero_run);
  assign eob_w = ANXB_CNT_W'(end_of_buffer);

  always_comb begin
    if (data_byte == ANXB_ZERO_BYTE) begin
      cls = CLS_ZERO;
    end else if (data_byte == ANXB_ONE_BYTE && zero_run[1]) begin
      cls = CLS_START;
    end else begin
      cls = CLS_OTHER;
    end
  end

  // Result count and next state for one byte.
  always_comb begin
    cnt                = '0;
    held_byte_next     = held_byte;
    held_valid_next    = held_valid;
    zero_run_next      = zero_run;
    inside_nal_next    = inside_nal;
    first_pending_next = first_pending;
    unique case (cls)
      CLS_ZERO: begin
        if (zero_run == ANXB_ZRUN_MAX) begin
          // The oldest zero of a long run becomes payload; at buffer end the
          // three remaining zeros follow it.
          cnt = hv_w + (end_of_buffer ? ANXB_CNT_W'(4) : '0);
          if (inside_nal) begin
            held_byte_next     = ANXB_ZERO_BYTE;
            held_valid_next    = 1'b1;
            first_pending_next = first_pending && !held_valid;
          end
        end else begin
          cnt           = end_of_buffer ? (hv_w + zr_w + ANXB_CNT_W'(1)) : '0;
          zero_run_next = zero_run + 2'd1;
        end
      end
      CLS_START: begin
        cnt                = hv_w;
        inside_nal_next    = 1'b1;
        first_pending_next = 1'b1;
        held_valid_next    = 1'b0;
        held_byte_next     = ANXB_ZERO_BYTE;
        zero_run_next      = '0;
      end
      CLS_OTHER: begin
        cnt = hv_w + zr_w + eob_w;
        if (inside_nal) begin
          held_byte_next     = data_byte;
          held_valid_next    = 1'b1;
          first_pending_next = first_pending && !held_valid && zero_run == 2'd0;
        end
        zero_run_next = '0;
      end
      default: begin
        cnt = '0;
      end
    endcase
    if (!inside_nal) begin
      cnt = '0;
    end
  end

  always_comb begin
    q_desc.cnt       = cnt;
    q_desc.held      = held_byte;
    q_desc.data      = data_byte;
    q_desc.head_held = held_valid;
    q_desc.tail_data = (cls == CLS_OTHER) && end_of_buffer;
    q_desc.first     = first_pending;
    q_desc.last      = (cls == CLS_START) || end_of_buffer;
  end

  assign q_push = accept && (cnt != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      held_byte     <= '0;
      held_valid    <= 1'b0;
      zero_run      <= '0;
      inside_nal    <= 1'b0;
      first_pending <= 1'b0;
    end else if (accept) begin
      if (end_of_buffer) begin
        held_byte     <= '0;
        held_valid    <= 1'b0;
        zero_run      <= '0;
        inside_nal    <= 1'b0;
        first_pending <= 1'b0;
      end else begin
        held_byte     <= held_byte_next;
        held_valid    <= held_valid_next;
        zero_run      <= zero_run_next;
        inside_nal    <= inside_nal_next;
        first_pending <= first_pending_next;
      end
    end
  end

endmodule

// File: src/anxb_queue.sv
// ----------------------------------------------------------------------------
// anxb_queue
// Small register queue of descriptors between the classifier and emitter.
// ----------------------------------------------------------------------------
module anxb_queue #(
  parameter int Depth = anxb_pkg::ANXB_QUEUE_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  anxb_pkg::anxb_desc_t push_desc,
  output logic                 full,
  input  logic                 pop,
  output logic                 head_valid,
  output anxb_pkg::anxb_desc_t head_desc
);
  import anxb_pkg::*;

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  anxb_desc_t      store [Depth];
  logic [PtrW-1:0] wptr;
  logic [PtrW-1:0] rptr;
  logic [CntW-1:0] count;

  assign full       = (count == FullCnt);
  assign head_valid = (count != '0);
  assign head_desc  = store[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      store[wptr] <= push_desc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == LastPtr) ? '0 : wptr + PtrW'(1);
      end
      if (pop) begin
        rptr <= (rptr == LastPtr) ? '0 : rptr + PtrW'(1);
      end
      if (push && !pop) begin
        count <= count + CntW'(1);
      end else if (pop && !push) begin
        count <= count - CntW'(1);
      end
    end
  end

endmodule

// File: src/anxb_back.sv
// ----------------------------------------------------------------------------
// anxb_back
// Expands each descriptor into its result bytes, one per cycle while the
// output is not stalled, into a registered output stage.
// ----------------------------------------------------------------------------
module anxb_back (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 head_valid,
  input  anxb_pkg::anxb_desc_t head_desc,
  output logic                 pop,
  output logic                 nal_valid,
  input  logic                 nal_ready,
  output logic [7:0]           nal_byte,
  output logic                 nal_first,
  output logic                 nal_last,
  output logic                 run_end
);
  import anxb_pkg::*;

  logic [ANXB_CNT_W-1:0] idx;
  logic [ANXB_CNT_W-1:0] last_idx;
  logic                  load;
  logic                  at_end;
  logic [7:0]            elem_byte;

  assign last_idx = head_desc.cnt - ANXB_CNT_W'(1);
  assign at_end   = (idx == last_idx);
  assign load     = head_valid && (!nal_valid || nal_ready);
  assign pop      = load && at_end;

  // Only the first and last result of a descriptor can be nonzero.
  always_comb begin
    if (idx == '0 && head_desc.head_held) begin
      elem_byte = head_desc.held;
    end else if (at_end && head_desc.tail_data) begin
      elem_byte = head_desc.data;
    end else begin
      elem_byte = ANXB_ZERO_BYTE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx       <= '0;
      nal_valid <= 1'b0;
    end else begin
      if (load) begin
        idx       <= at_end ? '0 : idx + ANXB_CNT_W'(1);
        nal_valid <= 1'b1;
      end else if (nal_ready) begin
        nal_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      nal_byte  <= elem_byte;
      nal_first <= (idx == '0) && head_desc.first;
      nal_last  <= at_end && head_desc.last;
      run_end   <= at_end;
    end
  end

endmodule

// File: src/annexb_nal_splitter.sv
// ----------------------------------------------------------------------------
// annexb_nal_splitter
// Splits an Annex B byte stream into NAL payload bytes with start codes
// removed, marking the first and last byte of every NAL.
// ----------------------------------------------------------------------------
//
//   channel  | valid      | ready      | payload
//   ---------+------------+------------+------------------------------------
//   input    | byte_valid | byte_ready | data_byte, end_of_buffer
//   output   | nal_valid  | nal_ready  | nal_byte, nal_first, nal_last,
//            |            |            | run_end
//
// One input byte is taken per cycle while the descriptor queue has room.
// The emitter sends one result per cycle while the output is not stalled; a
// byte causes N results (N is 0 to 5), and they are registered in the output
// stage once their descriptor reaches the head of the queue.
// Reset clears the start code state, the queue and the output stage.
// A stalled output fills the queue, which then holds byte_ready low.
// ----------------------------------------------------------------------------
module annexb_nal_splitter #(
  parameter int QueueDepth = anxb_pkg::ANXB_QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       byte_valid,
  output logic       byte_ready,
  input  logic [7:0] data_byte,
  input  logic       end_of_buffer,
  output logic       nal_valid,
  input  logic       nal_ready,
  output logic [7:0] nal_byte,
  output logic       nal_first,
  output logic       nal_last,
  output logic       run_end
);
  import anxb_pkg::*;

  anxb_desc_t push_desc;
  anxb_desc_t head_desc;
  logic       q_push;
  logic       q_full;
  logic       q_pop;
  logic       head_valid;

  anxb_front u_front (
    .clk           (clk),
    .rst           (rst),
    .byte_valid    (byte_valid),
    .byte_ready    (byte_ready),
    .data_byte     (data_byte),
    .end_of_buffer (end_of_buffer),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_desc        (push_desc)
  );

  anxb_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_desc  (push_desc),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (head_valid),
    .head_desc  (head_desc)
  );

  anxb_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_desc  (head_desc),
    .pop        (q_pop),
    .nal_valid  (nal_valid),
    .nal_ready  (nal_ready),
    .nal_byte   (nal_byte),
    .nal_first  (nal_first),
    .nal_last   (nal_last),
    .run_end    (run_end)
  );

endmodule

// File: verif/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the Annex B NAL splitter. A short table of
// hand-picked byte sequences is followed by random buffers made of start
// codes and zero-heavy payloads, mixed with unstructured noise. Every
// accepted byte runs through a behavioral splitter kept in the bench, and
// each result transaction is compared with the oldest expected payload byte.
// ----------------------------------------------------------------------------
module tb_top;
  import anxb_pkg::*;

  localparam int CLK_HALF    = 6;
  localparam int RESET_CYC   = 8;
  localparam int RAND_ITEMS  = 200;
  localparam int CALM_ITEMS  = 40;
  localparam int LONG_STALL  = 48;
  localparam int STALL_AT    = 60;
  localparam int DRAIN_AT    = 120;
  localparam int CYCLE_LIMIT = 300000;
  localparam int MAX_REPORTS = 10;
  localparam int DIR_N       = 27;

  typedef struct packed {
    logic [7:0] nbyte;
    logic       first;
    logic       last;
    logic       rend;
  } nal_res_t;

  // One input byte; known rows carry a typed-in result list of zero or one
  // entries that replaces the computed one.
  typedef struct packed {
    logic [7:0] data;
    logic       eob;
    logic       known;
    logic [2:0] exp_n;
    nal_res_t   exp_res;
  } byte_row_t;

  localparam nal_res_t NO_RES = '0;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       byte_valid = 1'b0;
  logic       byte_ready;
  logic [7:0] data_byte = 8'h00;
  logic       end_of_buffer = 1'b0;
  logic       nal_valid;
  logic       nal_ready = 1'b0;
  logic [7:0] nal_byte;
  logic       nal_first;
  logic       nal_last;
  logic       run_end;

  annexb_nal_splitter DUT (
    .clk          (clk),
    .rst          (rst),
    .byte_valid   (byte_valid),
    .byte_ready   (byte_ready),
    .data_byte    (data_byte),
    .end_of_buffer(end_of_buffer),
    .nal_valid    (nal_valid),
    .nal_ready    (nal_ready),
    .nal_byte     (nal_byte),
    .nal_first    (nal_first),
    .nal_last     (nal_last),
    .run_end      (run_end)
  );

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  // Splitter state kept by the bench.
  logic [7:0] pend_byte  = 8'h00;
  logic       pend_valid = 1'b0;
  logic [1:0] zeros_held = 2'd0;
  logic       in_nal     = 1'b0;
  logic       first_due  = 1'b0;

  nal_res_t  step_res[$];
  nal_res_t  nal_exp_q[$];
  byte_row_t rand_q[$];

  int  mismatches = 0;
  int  cycle_cnt  = 0;
  bit  calm       = 1'b0;
  bit  stall_req  = 1'b0;

  byte_row_t dir_tab [DIR_N] = '{
    '{8'hFF, 1'b1, 1'b1, 3'd0, NO_RES},  // no start code in the whole buffer
    '{8'h00, 1'b0, 1'b1, 3'd0, NO_RES},
    '{8'h00, 1'b0, 1'b1, 3'd0, NO_RES},
    '{8'h00, 1'b0, 1'b1, 3'd0, NO_RES},
    '{8'h00, 1'b0, 1'b1, 3'd0, NO_RES},  // fourth zero is dropped before any NAL
    '{8'h01, 1'b0, 1'b1, 3'd0, NO_RES},
    '{8'h80, 1'b0, 1'b1, 3'd0, NO_RES},
    '{8'h7F, 1'b0, 1'b1, 3'd1, '{8'h80, 1'b1, 1'b0, 1'b1}},
    '{8'h00, 1'b0, 1'b0, 3'd0, NO_RES},
    '{8'h01, 1'b0, 1'b0, 3'd0, NO_RES},  // a single zero before 01 is payload
    '{8'h00, 1'b0, 1'b0, 3'd0, NO_RES},
    '{8'h00, 1'b0, 1'b0, 3'd0, NO_RES},
    '{8'h00, 1'b0, 1'b0, 3'd0, NO_RES},
    '{8'h00, 1'b0, 1'b0, 3'd0, NO_RES},  // long zero run inside a NAL
    '{8'h01, 1'b0, 1'b0, 3'd0, NO_RES},
    '{8'h00, 1'b0, 1'b0, 3'd0, NO_RES},
    '{8'h00, 1'b0, 1'b0, 3'd0, NO_RES},
    '{8'h01, 1'b0, 1'b0, 3'd0, NO_RES},  // back-to-back start codes, empty NAL
    '{8'hFF, 1'b0, 1'b0, 3'd0, NO_RES},
    '{8'h00, 1'b1, 1'b0, 3'd0, NO_RES},  // held zero flushed at buffer end
    '{8'h00, 1'b0, 1'b0, 3'd0, NO_RES},
    '{8'h00, 1'b0, 1'b0, 3'd0, NO_RES},
    '{8'h01, 1'b0, 1'b0, 3'd0, NO_RES},
    '{8'h5A, 1'b0, 1'b0, 3'd0, NO_RES},
    '{8'h00, 1'b0, 1'b0, 3'd0, NO_RES},
    '{8'h00, 1'b0, 1'b0, 3'd0, NO_RES},
    '{8'h01, 1'b1, 1'b0, 3'd0, NO_RES}   // start code on the final byte
  };

  function automatic void put_result(logic [7:0] b, logic f, logic l);
    nal_res_t r;
    r.nbyte = b;
    r.first = f;
    r.last  = l;
    r.rend  = 1'b0;
    step_res.push_back(r);
  endfunction

  // A new payload byte releases the one held before it as a non-last byte.
  function automatic void add_payload(logic [7:0] b);
    if (pend_valid) begin
      put_result(pend_byte, first_due, 1'b0);
      first_due = 1'b0;
    end
    pend_byte  = b;
    pend_valid = 1'b1;
  endfunction

  function automatic void clear_split_state();
    pend_byte  = 8'h00;
    pend_valid = 1'b0;
    zeros_held = 2'd0;
    in_nal     = 1'b0;
    first_due  = 1'b0;
  endfunction

  function automatic void predict_split(logic [7:0] b, logic eob);
    step_res.delete();
    if (b == ANXB_ZERO_BYTE) begin
      if (zeros_held == ANXB_ZRUN_MAX) begin
        if (in_nal) add_payload(ANXB_ZERO_BYTE);
      end else begin
        zeros_held = zeros_held + 2'd1;
      end
    end else if (b == ANXB_ONE_BYTE && zeros_held >= 2'd2) begin
      if (in_nal && pend_valid) put_result(pend_byte, first_due, 1'b1);
      in_nal     = 1'b1;
      first_due  = 1'b1;
      pend_valid = 1'b0;
      pend_byte  = 8'h00;
      zeros_held = 2'd0;
    end else begin
      if (in_nal) begin
        for (int i = 0; i < zeros_held; i++) add_payload(ANXB_ZERO_BYTE);
        add_payload(b);
      end
      zeros_held = 2'd0;
    end
    if (eob) begin
      if (in_nal) begin
        for (int i = 0; i < zeros_held; i++) add_payload(ANXB_ZERO_BYTE);
        if (pend_valid) put_result(pend_byte, first_due, 1'b1);
      end
      clear_split_state();
    end
    if (step_res.size() > 0) step_res[step_res.size()-1].rend = 1'b1;
  endfunction

  function automatic void queue_byte(logic [7:0] b);
    byte_row_t row;
    row = '0;
    row.data = b;
    rand_q.push_back(row);
  endfunction

  function automatic void mark_buffer_end();
    byte_row_t row;
    row = rand_q.pop_back();
    row.eob = 1'b1;
    rand_q.push_back(row);
  endfunction

  // Payload content is zero-heavy so that long runs and near start codes occur.
  function automatic logic [7:0] payload_byte();
    case ($urandom_range(0, 9))
      0, 1, 2: return ANXB_ZERO_BYTE;
      3:       return ANXB_ONE_BYTE;
      4:       return 8'h03;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic void build_buffer();
    int lead;
    int n_nal;
    int zeros;
    int plen;
    lead  = $urandom_range(0, 3);
    n_nal = $urandom_range(1, 3);
    for (int i = 0; i < lead; i++) queue_byte(payload_byte());
    for (int n = 0; n < n_nal; n++) begin
      zeros = $urandom_range(2, 3);
      if ($urandom_range(0, 5) == 0) zeros += $urandom_range(1, 3);
      for (int i = 0; i < zeros; i++) queue_byte(ANXB_ZERO_BYTE);
      queue_byte(ANXB_ONE_BYTE);
      plen = $urandom_range(0, 8);
      for (int i = 0; i < plen; i++) queue_byte(payload_byte());
    end
    if ($urandom_range(0, 4) == 0) begin
      queue_byte(ANXB_ZERO_BYTE);
      queue_byte(ANXB_ZERO_BYTE);
      queue_byte(ANXB_ONE_BYTE);
    end
    mark_buffer_end();
  endfunction

  function automatic void build_noise();
    int len;
    len = $urandom_range(1, 10);
    for (int i = 0; i < len; i++) begin
      queue_byte($urandom_range(0, 1) ? payload_byte() : 8'($urandom_range(0, 255)));
      if ($urandom_range(0, 7) == 0) mark_buffer_end();
    end
  endfunction

  task automatic offer_byte(input byte_row_t row);
    int gap;
    gap = 0;
    if (!calm && $urandom_range(0, 5) == 0) gap = $urandom_range(1, 16);
    @(negedge clk);
    if (gap > 0) begin
      byte_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    byte_valid    <= 1'b1;
    data_byte     <= row.data;
    end_of_buffer <= row.eob;
    do @(posedge clk); while (!byte_ready);
    predict_split(row.data, row.eob);
    if (row.known) begin
      step_res.delete();
      if (row.exp_n != 3'd0) step_res.push_back(row.exp_res);
    end
    foreach (step_res[k]) nal_exp_q.push_back(step_res[k]);
  endtask

  task automatic note_mismatch(input string what, input nal_res_t want, input nal_res_t got);
    mismatches++;
    if (mismatches <= MAX_REPORTS) begin
      $display("%0t: %s: expected byte=%02h first=%b last=%b run_end=%b",
               $realtime, what, want.nbyte, want.first, want.last, want.rend);
      $display("%0t: %s: got byte=%02h first=%b last=%b run_end=%b",
               $realtime, what, got.nbyte, got.first, got.last, got.rend);
    end
  endtask

  // Output checker: each result transaction against the oldest expectation.
  always @(posedge clk) begin : check_out
    nal_res_t want;
    nal_res_t got;
    if (!rst && nal_valid && nal_ready) begin
      got = '{nal_byte, nal_first, nal_last, run_end};
      if (nal_exp_q.size() == 0) begin
        note_mismatch("unexpected result", NO_RES, got);
      end else begin
        want = nal_exp_q.pop_front();
        if (got.nbyte !== want.nbyte || got.first !== want.first ||
            got.last !== want.last || got.rend !== want.rend)
          note_mismatch("wrong result", want, got);
      end
    end
  end

  // Receiver: random stall bursts, one long hold-off on request, none when calm.
  initial begin
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      @(negedge clk);
      if (stall_req) begin
        nal_ready <= 1'b0;
        repeat (LONG_STALL) @(negedge clk);
        stall_req = 1'b0;
      end
      if (!calm && $urandom_range(0, 5) == 0) begin
        nal_ready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(negedge clk);
      end
      nal_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    while (rand_q.size() < RAND_ITEMS) begin
      if ($urandom_range(0, 6) == 0) build_noise();
      else build_buffer();
    end
    repeat (RESET_CYC) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (int i = 0; i < DIR_N; i++) offer_byte(dir_tab[i]);

    for (int i = 0; i < rand_q.size(); i++) begin
      if (i == STALL_AT) stall_req = 1'b1;
      if (i == DRAIN_AT) begin
        // Hold the input until the output side has caught up completely.
        @(negedge clk);
        byte_valid <= 1'b0;
        while (nal_exp_q.size() != 0) @(negedge clk);
      end
      if (i >= rand_q.size() - CALM_ITEMS) calm = 1'b1;
      offer_byte(rand_q[i]);
    end

    @(negedge clk);
    byte_valid <= 1'b0;
    while (nal_exp_q.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// File: files.f
src/anxb_pkg.sv
src/anxb_front.sv
src/anxb_queue.sv
src/anxb_back.sv
src/annexb_nal_splitter.sv
verif/tb_top.sv
